>>> hdl/cel_pkg.sv
// Shared types, register indexes, status codes and constants of the code entry lockout controller.
`timescale 1ns / 1ps

package cel_pkg;

   // Field widths of the channels and the configuration port.
   localparam int CODE_W_MAX   = 64;
   localparam int LEN_W        = 4;
   localparam int STATUS_W     = 3;
   localparam int SECONDS_W    = 11;
   localparam int COUNT_W      = 4;
   localparam int TICKS_W      = 20;
   localparam int ELAPSED_W    = 21;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 64;

   localparam int CODE_CHARS_DEFAULT = 8;

   typedef logic [STATUS_W-1:0]  status_type;
   typedef logic [CSR_IDX_W-1:0] csr_index_type;
   typedef logic [COUNT_W-1:0]   count_type;
   typedef logic [TICKS_W-1:0]   ticks_type;
   typedef logic [ELAPSED_W-1:0] elapsed_type;

   // Result status codes.
   localparam status_type ST_TICK        = 3'd0;
   localparam status_type ST_GRANTED     = 3'd1;
   localparam status_type ST_DENIED      = 3'd2;
   localparam status_type ST_DENIED_SOFT = 3'd3;
   localparam status_type ST_DENIED_HARD = 3'd4;
   localparam status_type ST_HARD_LOCKED = 3'd5;
   localparam status_type ST_SOFT_LOCKED = 3'd6;

   // Configuration register indexes.
   localparam csr_index_type REG_STORED_CODE     = 3'd0;
   localparam csr_index_type REG_STORED_LENGTH   = 3'd1;
   localparam csr_index_type REG_SOFT_FAIL_LIMIT = 3'd2;
   localparam csr_index_type REG_HARD_FAIL_LIMIT = 3'd3;
   localparam csr_index_type REG_SOFT_LOCK_TICKS = 3'd4;
   localparam csr_index_type REG_HARD_LOCK_TICKS = 3'd5;

   // Reset values of the configuration registers.
   localparam count_type SOFT_LIMIT_RESET = 4'd3;
   localparam count_type HARD_LIMIT_RESET = 4'd9;
   localparam ticks_type SOFT_TICKS_RESET = 20'd30000;
   localparam ticks_type HARD_TICKS_RESET = 20'd300000;

   localparam count_type   COUNT_MAX   = '1;
   localparam elapsed_type ELAPSED_MAX = '1;

   // Division by 1000 ticks per second: q = (d * DIV_RECIP) >> DIV_SHIFT is exact
   // for every d below 2**20.
   localparam int             DIV_SHIFT = 30;
   localparam int             PROD_W    = 41;
   localparam logic [20:0]    DIV_RECIP = 21'd1073742;

endpackage

>>> hdl/cel_req_if.sv
// Input channel of the lockout controller: valid, ready and one tick or code attempt.
`timescale 1ns / 1ps

interface cel_req_if;
   import cel_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  action;
   logic [CODE_W_MAX-1:0] entered_code;
   logic [LEN_W-1:0]      entered_length;

   modport source (output valid, output action, output entered_code,
                   output entered_length, input ready);
   modport sink   (input valid, input action, input entered_code,
                   input entered_length, output ready);
endinterface

>>> hdl/cel_rsp_if.sv
// Result channel of the lockout controller: valid, ready and one result item.
`timescale 1ns / 1ps

interface cel_rsp_if;
   import cel_pkg::*;

   logic                 valid;
   logic                 ready;
   status_type           status;
   logic [SECONDS_W-1:0] remaining_seconds;
   logic                 soft_locked;
   logic                 hard_locked;
   logic                 granted_light;

   modport source (output valid, output status, output remaining_seconds,
                   output soft_locked, output hard_locked, output granted_light,
                   input ready);
   modport sink   (input valid, input status, input remaining_seconds,
                   input soft_locked, input hard_locked, input granted_light,
                   output ready);
endinterface

>>> hdl/code_entry_lockout_controller.sv
// Top level of the code entry lockout controller: lock state, code compare and result pipeline.
`timescale 1ns / 1ps
// Pipeline: two register stages, stage A and the result register, where a result is offered.
// Throughput: one item per cycle unless the result channel stalls; stage A takes the state
// update and code compare, the result register the seconds calculation (multiply by a
// reciprocal of 1000). Each stage holds while its successor is full, so up to two results
// can be in flight.
// Reset (synchronous, active high) clears the lock state, the counts and both
// pipeline stages, and returns every configuration register to its default.

module code_entry_lockout_controller #(
   parameter int CODE_CHARS = cel_pkg::CODE_CHARS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   cel_req_if.sink                            req_port,
   cel_rsp_if.source                          rsp_port,
   input  logic                               csr_we,
   input  cel_pkg::csr_index_type             csr_index,
   input  logic [cel_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import cel_pkg::*;

   localparam int CODE_W = CODE_CHARS * 8;

   // ------------------------------------------------------------------
   // Configuration registers. The user must write them only while the block
   // is idle, as writes get no ordering against the item path; the block does
   // not enforce this. Indexes beyond the list are ignored.
   // ------------------------------------------------------------------
   logic [CODE_W-1:0] stored_code_ff;
   logic [LEN_W-1:0]  stored_length_ff;
   count_type         soft_limit_ff;
   count_type         hard_limit_ff;
   ticks_type         soft_ticks_ff;
   ticks_type         hard_ticks_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stored_code_ff   <= '0;
         stored_length_ff <= '0;
         soft_limit_ff    <= SOFT_LIMIT_RESET;
         hard_limit_ff    <= HARD_LIMIT_RESET;
         soft_ticks_ff    <= SOFT_TICKS_RESET;
         hard_ticks_ff    <= HARD_TICKS_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_STORED_CODE:     stored_code_ff   <= csr_wdata[CODE_W-1:0];
            REG_STORED_LENGTH:   stored_length_ff <= csr_wdata[LEN_W-1:0];
            REG_SOFT_FAIL_LIMIT: soft_limit_ff    <= csr_wdata[COUNT_W-1:0];
            REG_HARD_FAIL_LIMIT: hard_limit_ff    <= csr_wdata[COUNT_W-1:0];
            REG_SOFT_LOCK_TICKS: soft_ticks_ff    <= csr_wdata[TICKS_W-1:0];
            REG_HARD_LOCK_TICKS: hard_ticks_ff    <= csr_wdata[TICKS_W-1:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Pipeline handshake. Stage A holds the status, the lock flags and the
   // remaining lock ticks; the result register holds the finished item.
   // ------------------------------------------------------------------
   logic a_valid_ff;
   logic rsp_valid_ff;
   logic a_move;
   logic req_take;

   assign a_move         = a_valid_ff && (!rsp_valid_ff || rsp_port.ready);
   assign req_port.ready = !a_valid_ff || a_move;
   assign req_take       = req_port.valid && req_port.ready;

   // ------------------------------------------------------------------
   // Lock state.
   // ------------------------------------------------------------------
   logic        soft_active_ff, soft_active_in;
   logic        hard_active_ff, hard_active_in;
   count_type   soft_count_ff, soft_count_in;
   count_type   hard_count_ff, hard_count_in;
   elapsed_type soft_elapsed_ff, soft_elapsed_in;
   elapsed_type hard_elapsed_ff, hard_elapsed_in;
   logic        light_ff, light_in;

   // Code compare: the lengths must agree and stay within CODE_CHARS, and
   // every character below the length must match. Bytes above are ignored.
   logic [CODE_CHARS-1:0] char_ok;
   logic                  len_ok;
   logic                  code_match;

   always_comb begin
      for (int i = 0; i < CODE_CHARS; i++) begin
         char_ok[i] = (LEN_W'(i) >= req_port.entered_length) ||
                      (req_port.entered_code[i*8 +: 8] == stored_code_ff[i*8 +: 8]);
      end
   end

   assign len_ok     = (req_port.entered_length == stored_length_ff) &&
                       (req_port.entered_length <= LEN_W'(CODE_CHARS));
   assign code_match = len_ok && (&char_ok);

   // Saturating increments: the elapsed counts for the tick path, the fail counts for the miss path.
   count_type   soft_count_bump, hard_count_bump;
   elapsed_type soft_elapsed_bump, hard_elapsed_bump;

   assign soft_count_bump   = (soft_count_ff == COUNT_MAX) ? COUNT_MAX
                                                           : soft_count_ff + count_type'(1);
   assign hard_count_bump   = (hard_count_ff == COUNT_MAX) ? COUNT_MAX
                                                           : hard_count_ff + count_type'(1);
   assign soft_elapsed_bump = (soft_elapsed_ff == ELAPSED_MAX) ? ELAPSED_MAX
                                                : soft_elapsed_ff + elapsed_type'(1);
   assign hard_elapsed_bump = (hard_elapsed_ff == ELAPSED_MAX) ? ELAPSED_MAX
                                                : hard_elapsed_ff + elapsed_type'(1);

   // Remaining lock ticks, floored at zero when the lock length was lowered
   // below the time already spent.
   ticks_type soft_left, hard_left;

   assign soft_left = (soft_elapsed_ff >= {1'b0, soft_ticks_ff}) ? '0 :
                      soft_ticks_ff - soft_elapsed_ff[TICKS_W-1:0];
   assign hard_left = (hard_elapsed_ff >= {1'b0, hard_ticks_ff}) ? '0 :
                      hard_ticks_ff - hard_elapsed_ff[TICKS_W-1:0];

   status_type status_in;
   ticks_type  left_in;

   always_comb begin
      soft_active_in  = soft_active_ff;
      hard_active_in  = hard_active_ff;
      soft_count_in   = soft_count_ff;
      hard_count_in   = hard_count_ff;
      soft_elapsed_in = soft_elapsed_ff;
      hard_elapsed_in = hard_elapsed_ff;
      light_in        = light_ff;
      status_in       = ST_TICK;
      left_in         = '0;

      if (!req_port.action) begin
         // A tick ages each running lock; one that runs past its length ends
         // and takes its own fail count with it. The two locks are independent.
         if (hard_active_ff) begin
            hard_elapsed_in = hard_elapsed_bump;
            if (hard_elapsed_bump > {1'b0, hard_ticks_ff}) begin
               hard_active_in = 1'b0;
               hard_count_in  = '0;
            end
         end
         if (soft_active_ff) begin
            soft_elapsed_in = soft_elapsed_bump;
            if (soft_elapsed_bump > {1'b0, soft_ticks_ff}) begin
               soft_active_in = 1'b0;
               soft_count_in  = '0;
            end
         end
      end else begin
         // Every attempt puts the access indicator out; only a grant lights it.
         light_in = 1'b0;
         priority if (hard_active_ff) begin
            status_in = ST_HARD_LOCKED;
            left_in   = hard_left;
         end else if (soft_active_ff) begin
            status_in = ST_SOFT_LOCKED;
            left_in   = soft_left;
         end else if (code_match) begin
            status_in     = ST_GRANTED;
            light_in      = 1'b1;
            soft_count_in = '0;
            hard_count_in = '0;
         end else begin
            // A miss: the long lock takes precedence over the short one.
            soft_count_in = soft_count_bump;
            hard_count_in = hard_count_bump;
            priority if (hard_count_bump >= hard_limit_ff) begin
               status_in       = ST_DENIED_HARD;
               hard_elapsed_in = '0;
               hard_active_in  = 1'b1;
            end else if (soft_count_bump >= soft_limit_ff) begin
               status_in       = ST_DENIED_SOFT;
               soft_elapsed_in = '0;
               soft_active_in  = 1'b1;
            end else begin
               status_in = ST_DENIED;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         soft_active_ff  <= 1'b0;
         hard_active_ff  <= 1'b0;
         soft_count_ff   <= '0;
         hard_count_ff   <= '0;
         soft_elapsed_ff <= '0;
         hard_elapsed_ff <= '0;
         light_ff        <= 1'b0;
      end else if (req_take) begin
         soft_active_ff  <= soft_active_in;
         hard_active_ff  <= hard_active_in;
         soft_count_ff   <= soft_count_in;
         hard_count_ff   <= hard_count_in;
         soft_elapsed_ff <= soft_elapsed_in;
         hard_elapsed_ff <= hard_elapsed_in;
         light_ff        <= light_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage A: result of the state update, waiting for the seconds step.
   // ------------------------------------------------------------------
   status_type a_status_ff;
   ticks_type  a_left_ff;
   logic       a_soft_ff;
   logic       a_hard_ff;
   logic       a_light_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (req_take) begin
         a_valid_ff <= 1'b1;
      end else if (a_move) begin
         a_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         a_status_ff <= status_in;
         a_left_ff   <= left_in;
         a_soft_ff   <= soft_active_in;
         a_hard_ff   <= hard_active_in;
         a_light_ff  <= light_in;
      end
   end

   // ------------------------------------------------------------------
   // Result register. Whole seconds are the remaining ticks divided by
   // 1000, done as a multiply by a scaled reciprocal and a shift.
   // ------------------------------------------------------------------
   logic [PROD_W-1:0]    seconds_prod;
   logic [SECONDS_W-1:0] seconds_in;

   assign seconds_prod = PROD_W'(a_left_ff) * PROD_W'(DIV_RECIP);
   assign seconds_in   = seconds_prod[DIV_SHIFT +: SECONDS_W];

   status_type           rsp_status_ff;
   logic [SECONDS_W-1:0] rsp_seconds_ff;
   logic                 rsp_soft_ff;
   logic                 rsp_hard_ff;
   logic                 rsp_light_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (a_move) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_port.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (a_move) begin
         rsp_status_ff  <= a_status_ff;
         rsp_seconds_ff <= seconds_in;
         rsp_soft_ff    <= a_soft_ff;
         rsp_hard_ff    <= a_hard_ff;
         rsp_light_ff   <= a_light_ff;
      end
   end

   assign rsp_port.valid             = rsp_valid_ff;
   assign rsp_port.status            = rsp_status_ff;
   assign rsp_port.remaining_seconds = rsp_seconds_ff;
   assign rsp_port.soft_locked       = rsp_soft_ff;
   assign rsp_port.hard_locked       = rsp_hard_ff;
   assign rsp_port.granted_light     = rsp_light_ff;

endmodule
